/* rtl/ptp_pkg.sv */
// Shared constants, types and helpers of the pedal throttle plausibility block.
package ptp_pkg;

    // Table geometry and overlap levels
    localparam int SEGMENTS           = 8;
    localparam int OVERLAP_SET_LEVEL  = 250;
    localparam int OVERLAP_HOLD_LEVEL = 50;
    localparam int TBL_DEPTH          = 2 * SEGMENTS;
    localparam int ADDR_W             = $clog2(TBL_DEPTH);
    localparam int SEG_W              = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int BP_W       = 13;
    localparam int COEF_W     = 32;
    localparam int PM_W       = 10;
    localparam int TOL_W      = 7;
    localparam int TSEG_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = COEF_W + SAMPLE_W + 1;
    localparam int SUM_W      = PROD_W + 1;
    localparam int WHOLE_W    = SUM_W - 1 - FRAC_W;

    localparam logic [PM_W-1:0]  PERMILLE_FULL = PM_W'(1000);
    localparam logic [SEG_W-1:0] LAST_SEG      = SEG_W'(SEGMENTS - 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P1_MIN      = 3'd0,
        REG_P1_MAX      = 3'd1,
        REG_P2_MIN      = 3'd2,
        REG_P2_MAX      = 3'd3,
        REG_TOL         = 3'd4,
        REG_BRAKE_ACT   = 3'd5,
        REG_BRAKE_SHORT = 3'd6
    } t_reg_idx;

    // Item operation codes
    typedef enum logic {
        OP_SAMPLE      = 1'b0,
        OP_TABLE_WRITE = 1'b1
    } t_op;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_SCAN,
        S_ADD,
        S_SAVE,
        S_FIN
    } t_state;

    // One calibration table entry
    typedef struct packed {
        logic        [BP_W-1:0]   bp;
        logic signed [COEF_W-1:0] slope;
        logic signed [COEF_W-1:0] offset;
    } t_entry;

    // Stage enables of the shared multiply-add unit
    typedef struct packed {
        logic mul_en;
        logic add_en;
    } t_mac_ctl;

    // Table address of a segment of one sensor, sensor-major
    function automatic logic [ADDR_W-1:0] tbl_addr(input logic sensor,
                                                   input logic [SEG_W-1:0] seg);
        return sensor ? ADDR_W'(SEGMENTS) + ADDR_W'(seg) : ADDR_W'(seg);
    endfunction

endpackage

/* rtl/ptp_table.sv */
// Calibration table memory: one write port, one registered read port.
module ptp_table
    import ptp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_entry            o_rdata
);

    t_entry r_mem [TBL_DEPTH];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ptp_mac.sv */
// Shared multiply-add-clamp unit that maps a reading through one table segment.
module ptp_mac
    import ptp_pkg::*;
(
    input  logic                     i_clk,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [COEF_W-1:0] i_slope,
    input  logic signed [COEF_W-1:0] i_offset,
    input  logic [SAMPLE_W-1:0]      i_reading,
    output logic [PM_W-1:0]          o_permille
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [COEF_W-1:0] r_off;
    logic [PM_W-1:0]          r_permille;
    logic signed [SUM_W-1:0]  n_sum;
    logic [WHOLE_W-1:0]       n_whole;
    logic [PM_W-1:0]          n_permille;

    // Stage one: slope times reading, offset kept beside it
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_slope * $signed({1'b0, i_reading});
            r_off  <= i_offset;
        end
    end

    // Stage two: add offset, drop the fraction and clamp to 0..1000
    always_comb begin
        n_sum   = SUM_W'(r_prod) + SUM_W'(r_off);
        n_whole = n_sum[SUM_W-2:FRAC_W];
        if (n_sum[SUM_W-1]) begin
            n_permille = '0;
        end else if (n_whole > WHOLE_W'(PERMILLE_FULL)) begin
            n_permille = PERMILLE_FULL;
        end else begin
            n_permille = n_whole[PM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.add_en) begin
            r_permille <= n_permille;
        end
    end

    assign o_permille = r_permille;

endmodule

/* rtl/pedal_throttle_plausibility_core.sv */
// Top level of the pedal throttle plausibility block: sequencer, checks and result register.
//
// Usage: an item on the input channel (i_in_valid / o_in_ready) either writes one
// calibration table entry (operation 1) or processes one sample of two pedal readings
// and one brake reading (operation 0). A sample gives one result item on the output
// channel (o_out_valid / i_out_ready); a table write gives none.
// Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while
// the block is idle.
// Sequence: each pedal reading first checks the last breakpoint of its table, then
// scans segments one per cycle through the table's single read port, and the hit
// segment goes through the shared two-stage multiply-add unit. A reading at or above
// the last breakpoint skips the scan and maps to full scale. The block takes no new
// item while a sample is in work.
// The result sits in an output register; the next item is accepted while it waits.
// If the receiver stalls, a finished sample waits in its last step until the
// output register is free.
// Reset clears the configuration registers to their defaults and the overlap latch;
// the calibration table is undefined until written.
module pedal_throttle_plausibility_core
    import ptp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // Input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_operation,
    input  logic [SAMPLE_W-1:0]     i_pedal1_sample,
    input  logic [SAMPLE_W-1:0]     i_pedal2_sample,
    input  logic [SAMPLE_W-1:0]     i_brake_sample,
    input  logic                    i_table_sensor,
    input  logic [TSEG_W-1:0]       i_table_segment,
    input  logic [BP_W-1:0]         i_segment_breakpoint,
    input  logic signed [COEF_W-1:0] i_segment_slope,
    input  logic signed [COEF_W-1:0] i_segment_offset,
    // Output channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [PM_W-1:0]         o_throttle_permille,
    output logic [PM_W-1:0]         o_pedal1_permille,
    output logic [PM_W-1:0]         o_pedal2_permille,
    output logic                    o_brake_on,
    output logic                    o_throttle_on,
    output logic                    o_pedal_fault,
    output logic                    o_overlap_fault,
    output logic                    o_brake_short
);

    // Configuration registers
    logic [SAMPLE_W-1:0] r_p1_min, r_p1_max, r_p2_min, r_p2_max;
    logic [SAMPLE_W-1:0] r_brake_act, r_brake_short;
    logic [TOL_W-1:0]    r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_min      <= '0;
            r_p1_max      <= '1;
            r_p2_min      <= '0;
            r_p2_max      <= '1;
            r_tol         <= TOL_W'(10);
            r_brake_act   <= '0;
            r_brake_short <= '1;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_P1_MIN:      r_p1_min      <= i_cfg_data;
                REG_P1_MAX:      r_p1_max      <= i_cfg_data;
                REG_P2_MIN:      r_p2_min      <= i_cfg_data;
                REG_P2_MAX:      r_p2_max      <= i_cfg_data;
                REG_TOL:         r_tol         <= i_cfg_data[TOL_W-1:0];
                REG_BRAKE_ACT:   r_brake_act   <= i_cfg_data;
                REG_BRAKE_SHORT: r_brake_short <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and sample registers
    t_state              r_state, n_state;
    logic                r_sensor, n_sensor;
    logic [SEG_W-1:0]    r_seg, n_seg;
    logic [SAMPLE_W-1:0] r_r1, r_r2, r_brake;
    logic [PM_W-1:0]     r_p1, r_p2;
    logic                r_overlap;

    // Output register
    logic                r_o_valid;
    logic [PM_W-1:0]     r_o_throttle, r_o_p1, r_o_p2;
    logic                r_o_brake_on, r_o_throttle_on, r_o_fault, r_o_short;

    // Table and shared unit
    t_entry              tbl_rdata, tbl_wdata;
    logic                tbl_we, rd_en;
    logic [ADDR_W-1:0]   rd_addr, tbl_waddr;
    t_mac_ctl            mac_ctl;
    logic [PM_W-1:0]     mac_pm;
    logic [SAMPLE_W-1:0] cur_reading;
    logic                below_bp;
    logic                save_en, fin_en, out_free;
    logic [PM_W-1:0]     save_val;

    assign cur_reading = r_sensor ? r_r2 : r_r1;
    assign below_bp    = {1'b0, cur_reading} < tbl_rdata.bp;
    assign out_free    = !r_o_valid || i_out_ready;

    assign tbl_waddr = tbl_addr(i_table_sensor, SEG_W'(i_table_segment));
    assign tbl_wdata = '{bp: i_segment_breakpoint, slope: i_segment_slope,
                         offset: i_segment_offset};

    ptp_table u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (tbl_rdata)
    );

    ptp_mac u_mac (
        .i_clk      (i_clk),
        .i_ctl      (mac_ctl),
        .i_slope    (tbl_rdata.slope),
        .i_offset   (tbl_rdata.offset),
        .i_reading  (cur_reading),
        .o_permille (mac_pm)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and step controls
    always_comb begin
        n_state    = r_state;
        n_sensor   = r_sensor;
        n_seg      = r_seg;
        o_in_ready = 1'b0;
        tbl_we     = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = tbl_addr(r_sensor, LAST_SEG);
        mac_ctl    = '0;
        save_en    = 1'b0;
        save_val   = PERMILLE_FULL;
        fin_en     = 1'b0;
        case (r_state)
            S_IDLE: begin
                // No item is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    if (t_op'(i_operation) == OP_TABLE_WRITE) begin
                        tbl_we = int'(i_table_segment) < SEGMENTS;
                    end else begin
                        n_sensor = 1'b0;
                        rd_en    = 1'b1;
                        rd_addr  = tbl_addr(1'b0, LAST_SEG);
                        n_state  = S_LAST;
                    end
                end
            end
            S_LAST: begin
                if (!below_bp) begin
                    // Reading at or above the last breakpoint maps to full scale.
                    save_en = 1'b1;
                    if (!r_sensor) begin
                        n_sensor = 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = tbl_addr(1'b1, LAST_SEG);
                        n_state  = S_LAST;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_seg   = '0;
                    rd_en   = 1'b1;
                    rd_addr = tbl_addr(r_sensor, '0);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // The last segment always hits once the last-breakpoint check failed.
                if (below_bp || r_seg == LAST_SEG) begin
                    mac_ctl.mul_en = 1'b1;
                    n_state        = S_ADD;
                end else begin
                    n_seg   = r_seg + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = tbl_addr(r_sensor, r_seg + 1'b1);
                end
            end
            S_ADD: begin
                mac_ctl.add_en = 1'b1;
                n_state        = S_SAVE;
            end
            S_SAVE: begin
                save_en  = 1'b1;
                save_val = mac_pm;
                if (!r_sensor) begin
                    n_sensor = 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = tbl_addr(1'b1, LAST_SEG);
                    n_state  = S_LAST;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    fin_en  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sample and per-sensor result registers
    always_ff @(posedge i_clk) begin
        r_sensor <= n_sensor;
        r_seg    <= n_seg;
        if (r_state == S_IDLE && i_in_valid) begin
            r_r1    <= i_pedal1_sample;
            r_r2    <= i_pedal2_sample;
            r_brake <= i_brake_sample;
        end
        if (save_en) begin
            if (r_sensor) begin
                r_p2 <= save_val;
            end else begin
                r_p1 <= save_val;
            end
        end
    end

    // Average, agreement and range checks, brake levels and overlap latch
    logic [PM_W:0]   sum_p;
    logic [PM_W-1:0] avg, diff;
    logic [PM_W:0]   tol_lim;
    logic            agree_fault, range_fault, brake_on, n_overlap;

    always_comb begin
        sum_p   = {1'b0, r_p1} + {1'b0, r_p2};
        avg     = sum_p[PM_W:1];
        diff    = (r_p1 > r_p2) ? r_p1 - r_p2 : r_p2 - r_p1;
        // diff / 10 > tol is the same as diff >= 10 * tol + 10.
        tol_lim = (PM_W+1)'({r_tol, 3'b000}) + (PM_W+1)'({r_tol, 1'b0})
                + (PM_W+1)'(10);
        agree_fault = {1'b0, diff} >= tol_lim;
        range_fault = r_r2 > r_p2_max || r_r2 < r_p2_min
                   || r_r1 > r_p1_max || r_r1 < r_p1_min;
        brake_on    = r_brake > r_brake_act;
        if (r_overlap) begin
            n_overlap = avg >= PM_W'(OVERLAP_HOLD_LEVEL);
        end else begin
            n_overlap = avg > PM_W'(OVERLAP_SET_LEVEL) && brake_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overlap <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (fin_en) begin
                r_overlap <= n_overlap;
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (fin_en) begin
            r_o_throttle    <= avg;
            r_o_p1          <= r_p1;
            r_o_p2          <= r_p2;
            r_o_brake_on    <= brake_on;
            r_o_throttle_on <= avg != '0;
            r_o_fault       <= range_fault || agree_fault;
            r_o_short       <= r_brake > r_brake_short;
        end
    end

    assign o_out_valid         = r_o_valid;
    assign o_throttle_permille = r_o_throttle;
    assign o_pedal1_permille   = r_o_p1;
    assign o_pedal2_permille   = r_o_p2;
    assign o_brake_on          = r_o_brake_on;
    assign o_throttle_on       = r_o_throttle_on;
    assign o_pedal_fault       = r_o_fault;
    assign o_overlap_fault     = r_overlap;
    assign o_brake_short       = r_o_short;

    // Per-sensor values never exceed full scale.
    a_pm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pedal1_permille <= PERMILLE_FULL
                     && o_pedal2_permille <= PERMILLE_FULL)
        else $error("per-sensor throttle above full scale");

    // The average lies between the two sensor values.
    a_avg_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_throttle_permille >= o_pedal1_permille
                         || o_throttle_permille >= o_pedal2_permille)
                     && (o_throttle_permille <= o_pedal1_permille
                         || o_throttle_permille <= o_pedal2_permille))
        else $error("average outside the sensor values");

    // The overlap latch only sets with the brake on and throttle above the set level.
    a_overlap_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_overlap) |-> r_o_brake_on
                          && r_o_throttle > PM_W'(OVERLAP_SET_LEVEL))
        else $error("overlap latch set without brake and throttle");

    // A new result is only loaded while the output register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
                                     && $stable(o_pedal_fault)
                                     && $stable(r_overlap))
        else $error("pending result overwritten");

endmodule

/* bench/pedal_throttle_plausibility_core_tb.sv */
// Self-checking testbench for the pedal throttle plausibility core.
`timescale 1ns / 100ps

module pedal_throttle_plausibility_core_tb;
    import ptp_pkg::*;

    localparam int NUM_PHASES       = 6;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int SETTLE_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int MAX_REPORTED     = 10;

    // One item on the input channel, with an optional hand-computed report.
    typedef struct {
        logic [PM_W-1:0] throttle;
        logic [PM_W-1:0] pedal1_pm;
        logic [PM_W-1:0] pedal2_pm;
        logic            brake_on;
        logic            throttle_on;
        logic            pedal_fault;
        logic            overlap_fault;
        logic            brake_short;
    } t_report;

    typedef struct {
        t_op                      op;
        logic [SAMPLE_W-1:0]      pedal1;
        logic [SAMPLE_W-1:0]      pedal2;
        logic [SAMPLE_W-1:0]      brake;
        logic                     sensor;
        logic [TSEG_W-1:0]        segment;
        logic [BP_W-1:0]          breakpoint;
        logic signed [COEF_W-1:0] slope;
        logic signed [COEF_W-1:0] offset;
        bit                       has_known;
        t_report                  known;
    } t_pedal_item;

    typedef struct {
        logic [BP_W-1:0]          bp;
        logic signed [COEF_W-1:0] slope;
        logic signed [COEF_W-1:0] offset;
    } t_cal_entry;

    // Block inputs, all known from time zero.
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_idx = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     operation = 1'b0;
    logic [SAMPLE_W-1:0]      pedal1_sample = '0;
    logic [SAMPLE_W-1:0]      pedal2_sample = '0;
    logic [SAMPLE_W-1:0]      brake_sample = '0;
    logic                     table_sensor = 1'b0;
    logic [TSEG_W-1:0]        table_segment = '0;
    logic [BP_W-1:0]          segment_breakpoint = '0;
    logic signed [COEF_W-1:0] segment_slope = '0;
    logic signed [COEF_W-1:0] segment_offset = '0;
    logic                     out_ready = 1'b0;

    // Block outputs.
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic [PM_W-1:0]          o_throttle_permille;
    logic [PM_W-1:0]          o_pedal1_permille;
    logic [PM_W-1:0]          o_pedal2_permille;
    logic                     o_brake_on;
    logic                     o_throttle_on;
    logic                     o_pedal_fault;
    logic                     o_overlap_fault;
    logic                     o_brake_short;

    // Shadow copy of the block's state and registers.
    t_cal_entry  cal_model [2][SEGMENTS];
    bit          overlap_model = 1'b0;
    int unsigned lim_p1_min = 0;
    int unsigned lim_p1_max = 4095;
    int unsigned lim_p2_min = 0;
    int unsigned lim_p2_max = 4095;
    int unsigned agree_tol = 10;
    int unsigned brake_act_level = 0;
    int unsigned brake_short_level = 4095;

    // Items waiting to be offered and reports waiting to arrive.
    t_pedal_item stim_q [$];
    t_pedal_item offered;
    t_report     expected_reports [$];

    // Traffic shaping.
    int  send_burst_max = 1;
    int  send_gap_max = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  recv_stall_pct = 0;
    int  recv_stall_max = 1;
    int  stall_left = 0;
    bit  hold_off = 1'b0;
    int  phase_idx = 0;

    // Bookkeeping.
    int  queued_count = 0;
    int  accepted_count = 0;
    int  samples_done = 0;
    int  writes_done = 0;
    int  reports_seen = 0;
    int  report_errors = 0;
    int  overlap_seen = 0;
    int  fault_seen = 0;
    int  short_seen = 0;
    int  cycle_count = 0;

    pedal_throttle_plausibility_core DUT (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_idx            (cfg_idx),
        .i_cfg_data           (cfg_data),
        .i_in_valid           (in_valid),
        .o_in_ready           (o_in_ready),
        .i_operation          (operation),
        .i_pedal1_sample      (pedal1_sample),
        .i_pedal2_sample      (pedal2_sample),
        .i_brake_sample       (brake_sample),
        .i_table_sensor       (table_sensor),
        .i_table_segment      (table_segment),
        .i_segment_breakpoint (segment_breakpoint),
        .i_segment_slope      (segment_slope),
        .i_segment_offset     (segment_offset),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (out_ready),
        .o_throttle_permille  (o_throttle_permille),
        .o_pedal1_permille    (o_pedal1_permille),
        .o_pedal2_permille    (o_pedal2_permille),
        .o_brake_on           (o_brake_on),
        .o_throttle_on        (o_throttle_on),
        .o_pedal_fault        (o_pedal_fault),
        .o_overlap_fault      (o_overlap_fault),
        .o_brake_short        (o_brake_short)
    );

    // Free-running clock.
    initial begin
        forever #10 clk = ~clk;
    end

    // Maps one pedal reading through its sensor's calibration table.
    function automatic logic [PM_W-1:0] permille_of(int sensor, logic [SAMPLE_W-1:0] reading);
        longint acc;
        longint whole;
        if (reading >= cal_model[sensor][SEGMENTS-1].bp) return PERMILLE_FULL;
        for (int s = 0; s < SEGMENTS; s++) begin
            if (reading < cal_model[sensor][s].bp) begin
                acc = longint'(cal_model[sensor][s].slope) * longint'(reading)
                    + longint'(cal_model[sensor][s].offset);
                if (acc < 0) return '0;
                whole = acc >>> FRAC_W;
                return (whole > 1000) ? PERMILLE_FULL : PM_W'(whole);
            end
        end
        return '0;
    endfunction

    // Applies one accepted item to the shadow state and records the report it causes.
    function automatic void advance_pedal_model(t_pedal_item it);
        t_report     rep;
        int unsigned avg;
        int unsigned diff;
        bit          range_bad;
        if (it.op == OP_TABLE_WRITE) begin
            cal_model[it.sensor][it.segment].bp     = it.breakpoint;
            cal_model[it.sensor][it.segment].slope  = it.slope;
            cal_model[it.sensor][it.segment].offset = it.offset;
            writes_done++;
            return;
        end
        rep.pedal1_pm = permille_of(0, it.pedal1);
        rep.pedal2_pm = permille_of(1, it.pedal2);
        avg  = (int'(rep.pedal1_pm) + int'(rep.pedal2_pm)) / 2;
        diff = (rep.pedal1_pm > rep.pedal2_pm) ? rep.pedal1_pm - rep.pedal2_pm
                                               : rep.pedal2_pm - rep.pedal1_pm;
        range_bad = it.pedal1 < lim_p1_min || it.pedal1 > lim_p1_max
                 || it.pedal2 < lim_p2_min || it.pedal2 > lim_p2_max;
        rep.throttle    = PM_W'(avg);
        rep.brake_on    = it.brake > brake_act_level;
        rep.throttle_on = avg > 0;
        rep.pedal_fault = range_bad || (diff / 10) > agree_tol;
        rep.brake_short = it.brake > brake_short_level;
        // The latch sets on hard throttle with the brake on and holds at or above the lower level.
        if (overlap_model) overlap_model = avg >= OVERLAP_HOLD_LEVEL;
        else overlap_model = avg > OVERLAP_SET_LEVEL && rep.brake_on;
        rep.overlap_fault = overlap_model;
        expected_reports.push_back(it.has_known ? it.known : rep);
        samples_done++;
    endfunction

    // Item builders; fields the operation ignores still get random values.
    function automatic t_pedal_item sample_item(int p1, int p2, int brake);
        t_pedal_item it;
        it.op         = OP_SAMPLE;
        it.pedal1     = SAMPLE_W'(p1);
        it.pedal2     = SAMPLE_W'(p2);
        it.brake      = SAMPLE_W'(brake);
        it.sensor     = $urandom_range(0, 1);
        it.segment    = TSEG_W'($urandom_range(0, 7));
        it.breakpoint = BP_W'($urandom_range(0, 4096));
        it.slope      = $urandom;
        it.offset     = $urandom;
        it.has_known  = 1'b0;
        it.known      = '{default: '0};
        return it;
    endfunction

    function automatic t_pedal_item table_item(int sensor, int seg, int bp, int slope,
                                               int offset);
        t_pedal_item it;
        it            = sample_item($urandom_range(0, 4095), $urandom_range(0, 4095),
                                    $urandom_range(0, 4095));
        it.op         = OP_TABLE_WRITE;
        it.sensor     = sensor[0];
        it.segment    = TSEG_W'(seg);
        it.breakpoint = BP_W'(bp);
        it.slope      = slope;
        it.offset     = offset;
        return it;
    endfunction

    function automatic t_pedal_item known_sample(int p1, int p2, int brake, int thr, int pm1,
                                                 int pm2, bit bon, bit ton, bit flt, bit ovl,
                                                 bit shrt);
        t_pedal_item it;
        it = sample_item(p1, p2, brake);
        it.has_known = 1'b1;
        it.known     = '{PM_W'(thr), PM_W'(pm1), PM_W'(pm2), bon, ton, flt, ovl, shrt};
        return it;
    endfunction

    // A plausible calibration entry: rising breakpoints and roughly full-scale slope.
    function automatic t_pedal_item calibrated_entry(int sensor, int seg);
        int bp;
        int slope;
        int offset;
        if (seg == SEGMENTS - 1) bp = $urandom_range(3800, 4096);
        else bp = (seg + 1) * 480 + int'($urandom_range(0, 60));
        slope  = 16003 + int'($urandom_range(0, 3000)) - 1500;
        offset = (int'($urandom_range(0, 60)) - 30) * 65536;
        return table_item(sensor, seg, bp, slope, offset);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_reading();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Mostly agreeing pedal pairs, with edge readings and brake extremes mixed in.
    function automatic t_pedal_item random_sample();
        int p1;
        int p2;
        int brake;
        p1 = pick_reading();
        if ($urandom_range(0, 9) < 6) begin
            p2 = p1 + int'($urandom_range(0, 120)) - 60;
            p2 = (p2 < 0) ? 0 : (p2 > 4095) ? 4095 : p2;
        end else begin
            p2 = pick_reading();
        end
        case ($urandom_range(0, 9))
            0, 1, 2: brake = 0;
            3:       brake = 4095;
            default: brake = $urandom_range(0, 4095);
        endcase
        return sample_item(p1, p2, brake);
    endfunction

    function automatic void queue_item(t_pedal_item it);
        stim_q.push_back(it);
        queued_count++;
    endfunction

    // Simple quarter-scale tables used by the hand-computed rows.
    function automatic void queue_linear_tables();
        for (int s = 0; s < 2; s++) begin
            for (int g = 0; g < SEGMENTS; g++) begin
                queue_item(table_item(s, g, (g == SEGMENTS - 1) ? 4000 : 512 * (g + 1),
                                      16384, 0));
            end
        end
    endfunction

    function automatic void queue_calibration();
        for (int s = 0; s < 2; s++) begin
            for (int g = 0; g < SEGMENTS; g++) queue_item(calibrated_entry(s, g));
        end
    endfunction

    function automatic void queue_random(int count);
        int k;
        repeat (count) begin
            k = $urandom_range(0, 99);
            if (k < 12) begin
                queue_item(calibrated_entry($urandom_range(0, 1), $urandom_range(0, SEGMENTS - 1)));
            end else if (k < 15) begin
                queue_item(table_item($urandom_range(0, 1), $urandom_range(0, SEGMENTS - 1),
                                      $urandom_range(0, 4096), $urandom, $urandom));
            end else begin
                queue_item(random_sample());
            end
        end
    endfunction

    // Hand-checked rows first, then corner entries checked by the shadow model.
    function automatic void queue_directed();
        t_pedal_item rows [$];
        //                     p1    p2    brake thr   pm1   pm2  bon ton flt ovl sht
        rows.push_back(known_sample(0,    0,    0,    0,    0,    0,   0,  0,  0,  0,  0));
        rows.push_back(known_sample(4095, 4095, 0,    1000, 1000, 1000, 0,  1,  0,  0,  0));
        // Brake on with full throttle sets the overlap latch, which holds at 100.
        rows.push_back(known_sample(4095, 4095, 4095, 1000, 1000, 1000, 1,  1,  0,  1,  0));
        rows.push_back(known_sample(400,  400,  0,    100,  100,  100,  0,  1,  0,  1,  0));
        // Dropping below the hold level releases it.
        rows.push_back(known_sample(196,  196,  0,    49,   49,   49,   0,  1,  0,  0,  0));
        rows.push_back(known_sample(4095, 0,    0,    500,  1000, 0,    0,  1,  1,  0,  0));
        // Disagreement right at and just past the default tolerance.
        rows.push_back(known_sample(436,  0,    0,    54,   109,  0,    0,  1,  0,  0,  0));
        rows.push_back(known_sample(440,  0,    0,    55,   110,  0,    0,  1,  1,  0,  0));
        // Exactly on the last breakpoint versus one below it.
        rows.push_back(known_sample(4000, 3999, 0,    999,  1000, 999,  0,  1,  0,  0,  0));
        // Negative result, saturation and the extreme coefficient values.
        rows.push_back(table_item(0, 0, 512, 32'h8000_0000, 0));
        rows.push_back(table_item(1, 0, 512, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        rows.push_back(sample_item(100, 100, 4095));
        rows.push_back(table_item(0, 1, 1024, 0, 32'h8000_0000));
        rows.push_back(table_item(1, 1, 1024, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        rows.push_back(sample_item(600, 600, 0));
        // A zero breakpoint is never hit; the widest breakpoint takes every reading.
        rows.push_back(table_item(0, 2, 0, 16384, 0));
        rows.push_back(table_item(1, SEGMENTS - 1, 4096, 16384, 0));
        rows.push_back(sample_item(1100, 4095, 0));
        foreach (rows[i]) queue_item(rows[i]);
    endfunction

    // Configuration writes, mirrored into the shadow registers.
    task automatic write_reg(t_reg_idx idx, int unsigned value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(value);
        case (idx)
            REG_P1_MIN:      lim_p1_min = value;
            REG_P1_MAX:      lim_p1_max = value;
            REG_P2_MIN:      lim_p2_min = value;
            REG_P2_MAX:      lim_p2_max = value;
            REG_TOL:         agree_tol = value;
            REG_BRAKE_ACT:   brake_act_level = value;
            REG_BRAKE_SHORT: brake_short_level = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(int p);
        case (p)
            1: begin
                write_reg(REG_P1_MIN, 0);
                write_reg(REG_P1_MAX, 4095);
                write_reg(REG_P2_MIN, 0);
                write_reg(REG_P2_MAX, 4095);
                write_reg(REG_TOL, 0);
                write_reg(REG_BRAKE_ACT, 0);
                write_reg(REG_BRAKE_SHORT, 0);
            end
            2: begin
                write_reg(REG_P1_MIN, 4095);
                write_reg(REG_P1_MAX, 0);
                write_reg(REG_P2_MIN, 4095);
                write_reg(REG_P2_MAX, 0);
                write_reg(REG_TOL, 100);
                write_reg(REG_BRAKE_ACT, 4095);
                write_reg(REG_BRAKE_SHORT, 4095);
            end
            default: begin
                write_reg(REG_P1_MIN, $urandom_range(0, 600));
                write_reg(REG_P1_MAX, $urandom_range(3400, 4095));
                write_reg(REG_P2_MIN, $urandom_range(0, 600));
                write_reg(REG_P2_MAX, $urandom_range(3400, 4095));
                write_reg(REG_TOL, $urandom_range(0, 100));
                write_reg(REG_BRAKE_ACT, $urandom_range(0, 4095));
                write_reg(REG_BRAKE_SHORT, $urandom_range(2000, 4095));
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Each phase pairs a sender pattern with a different receiver pattern.
    function automatic void set_idle_modes(int p);
        case (p % 3)
            0: begin
                send_burst_max = 1;  send_gap_max = 0;
                recv_stall_pct = 25; recv_stall_max = 6;
            end
            1: begin
                send_burst_max = 8;  send_gap_max = 3;
                recv_stall_pct = 0;  recv_stall_max = 1;
            end
            default: begin
                send_burst_max = 3;  send_gap_max = 12;
                recv_stall_pct = 50; recv_stall_max = 16;
            end
        endcase
    endfunction

    task automatic wait_idle();
        while (accepted_count != queued_count || expected_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: offers queued items in bursts and updates the shadow model on acceptance.
    always @(posedge clk) begin : item_sender
        if (rst_n) begin
            if (in_valid && o_in_ready) begin
                advance_pedal_model(offered);
                accepted_count++;
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    offered = stim_q.pop_front();
                    operation          <= offered.op;
                    pedal1_sample      <= offered.pedal1;
                    pedal2_sample      <= offered.pedal2;
                    brake_sample       <= offered.brake;
                    table_sensor       <= offered.sensor;
                    table_segment      <= offered.segment;
                    segment_breakpoint <= offered.breakpoint;
                    segment_slope      <= offered.slope;
                    segment_offset     <= offered.offset;
                    in_valid           <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, send_burst_max);
                        gap_left   = (send_gap_max > 0) ? $urandom_range(1, send_gap_max) : 0;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall runs, overridden by the long hold-off.
    always @(posedge clk) begin : report_receiver
        if (hold_off) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < recv_stall_pct) stall_left = $urandom_range(1, recv_stall_max);
        end
    end

    // Long receiver stall early in phase one so the block backs up into its input.
    initial begin : long_hold
        wait (phase_idx == 1);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            report_errors++;
            if (report_errors <= MAX_REPORTED) begin
                $display("Mismatch in %s of report %0d: expected %0d, got %0d",
                         name, reports_seen, want, got);
            end
        end
    endfunction

    // Checker: every accepted report against the oldest expectation.
    always @(posedge clk) begin : report_checker
        t_report want;
        if (rst_n && o_out_valid && out_ready) begin
            reports_seen++;
            overlap_seen += o_overlap_fault;
            fault_seen   += o_pedal_fault;
            short_seen   += o_brake_short;
            if (expected_reports.size() == 0) begin
                report_errors++;
                if (report_errors <= MAX_REPORTED) begin
                    $display("Report %0d arrived with none expected (throttle %0d)",
                             reports_seen, o_throttle_permille);
                end
            end else begin
                want = expected_reports.pop_front();
                check_field("throttle_permille", want.throttle, o_throttle_permille);
                check_field("pedal1_permille", want.pedal1_pm, o_pedal1_permille);
                check_field("pedal2_permille", want.pedal2_pm, o_pedal2_permille);
                check_field("brake_on", want.brake_on, o_brake_on);
                check_field("throttle_on", want.throttle_on, o_throttle_on);
                check_field("pedal_fault", want.pedal_fault, o_pedal_fault);
                check_field("overlap_fault", want.overlap_fault, o_overlap_fault);
                check_field("brake_short", want.brake_short, o_brake_short);
            end
        end
    end

    // Run limit.
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped at the cycle limit with %0d reports outstanding",
                 expected_reports.size());
        $display("FAILURE");
        $finish;
    end

    // Main sequence: reset, directed rows, then random traffic under several register settings.
    initial begin : main_sequence
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_idle_modes(0);
        queue_linear_tables();
        queue_directed();
        queue_calibration();
        queue_random(RANDOM_PER_PHASE);
        wait_idle();
        for (int p = 1; p < NUM_PHASES; p++) begin
            phase_idx = p;
            set_idle_modes(p);
            apply_settings(p);
            queue_calibration();
            queue_random(RANDOM_PER_PHASE);
            wait_idle();
        end
        if (expected_reports.size() != 0) begin
            $display("%0d expected reports never arrived", expected_reports.size());
        end
        $display("Ran %0d samples and %0d table writes over %0d register settings.",
                 samples_done, writes_done, NUM_PHASES);
        $display("Reports checked: %0d; overlap %0d, pedal fault %0d, brake short %0d.",
                 reports_seen, overlap_seen, fault_seen, short_seen);
        if (report_errors == 0 && expected_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ptp_pkg.sv
rtl/ptp_table.sv
rtl/ptp_mac.sv
rtl/pedal_throttle_plausibility_core.sv
bench/pedal_throttle_plausibility_core_tb.sv
